// ===== rtl/rcc_pkg.sv =====
// Shared types and constants for the RGB 3x3 convolution filter.
`default_nettype none
package rcc_pkg;

  localparam int PIX_W  = 24;
  localparam int ROW_W  = 17;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // item kind carried on in_tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // one filter job: masked 3x3 window (index row*3 + column), pixels packed
  // red 23:16, green 15:8, blue 7:0
  typedef struct packed {
    logic [8:0][PIX_W-1:0] px;
    logic                  last;
  } rcc_job_t;

endpackage
`default_nettype wire

// ===== rtl/rcc_front.sv =====
// Front end: position counters, line stores, 3x3 window and job building.
`default_nettype none
module rcc_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,
  input  logic                      in_tuser,
  input  logic [11:0]               frame_width,
  input  logic [15:0]               frame_height,
  input  logic [rcc_pkg::QCNT_W-1:0] q_count,
  output logic                      q_push,
  output rcc_pkg::rcc_job_t         q_job
);
  import rcc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > 12) ? WW : 12;

  typedef struct packed {
    logic [AW-1:0]    col;
    logic [PIX_W-1:0] pix;
    logic             emit;
    logic             top;
    logic             bottom;
    logic             left;
    logic             right;
    logic             last;
  } s1_t;

  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             clearing_r, clearing_nxt;
  logic [AW-1:0]    clr_idx_r, clr_idx_nxt;
  logic             s1_v_r;
  s1_t              s1_r, s1_nxt;
  logic             byp_v_r;
  logic [AW-1:0]    byp_col_r;
  logic [PIX_W-1:0] byp_up_r, byp_lo_r;
  logic [PIX_W-1:0] up_rd_r, lo_rd_r;
  logic [8:0][PIX_W-1:0] win_r, win_nxt;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

  logic [CW-1:0]    w_eff;
  logic [ROW_W-1:0] h_x;
  logic             wrap, col_nz, end_of_row, accept;
  logic [AW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic             hit;
  logic [PIX_W-1:0] up_eff, lo_eff;
  logic             mem_we;
  logic [AW-1:0]    wr_addr;
  logic [PIX_W-1:0] wr_up, wr_lo;

  assign in_tready = !clearing_r &&
                     (({1'b0, q_count} + {{QCNT_W{1'b0}}, s1_v_r}) < (QCNT_W + 1)'(QDEPTH));
  assign accept = in_tvalid && in_tready;

  // ---- stage 0: position of the incoming item ----
  always_comb begin
    if (frame_width == '0) begin
      w_eff = CW'(1);
    end else if (CW'(frame_width) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    h_x = (frame_height == '0) ? ROW_W'(1) : ROW_W'(frame_height);

    // width shrunk under the counter: wrap before use
    wrap       = CW'(col_r) >= w_eff;
    col        = wrap ? '0 : col_r;
    row        = wrap ? row_r + ROW_W'(1) : row_r;
    col_nz     = (col != '0);
    end_of_row = (CW'(col) + CW'(1)) >= w_eff;

    s1_nxt.col    = col;
    s1_nxt.pix    = (in_tuser == OP_PIXEL && row < h_x) ?
                    {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]} : '0;
    s1_nxt.emit   = (row >= ROW_W'(2)) || (row == ROW_W'(1) && col_nz);
    // output sits one row up and one column left, or at the row end two rows up
    s1_nxt.top    = col_nz ? (row == ROW_W'(1)) : (row <= ROW_W'(2));
    s1_nxt.bottom = col_nz ? (row >= h_x) : (row >= h_x + ROW_W'(1));
    s1_nxt.left   = col_nz ? (col == AW'(1)) : (w_eff == CW'(1));
    s1_nxt.right  = !col_nz;
    s1_nxt.last   = s1_nxt.emit && !col_nz && s1_nxt.bottom;

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (s1_nxt.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (end_of_row) begin
        col_nxt = '0;
        row_nxt = row + ROW_W'(1);
      end else begin
        col_nxt = col + AW'(1);
        row_nxt = row;
      end
    end
  end

  // ---- clearing sweep of the line stores after reset ----
  always_comb begin
    clearing_nxt = clearing_r;
    clr_idx_nxt  = clr_idx_r;
    if (clearing_r) begin
      clr_idx_nxt = clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(MAX_WIDTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  // ---- stage 1: line store data, forwarding of the write one item back ----
  always_comb begin
    hit    = byp_v_r && (byp_col_r == s1_r.col);
    up_eff = hit ? byp_up_r : up_rd_r;
    lo_eff = hit ? byp_lo_r : lo_rd_r;

    mem_we  = clearing_r || s1_v_r;
    wr_addr = clearing_r ? clr_idx_r : s1_r.col;
    wr_up   = clearing_r ? '0 : lo_eff;
    wr_lo   = clearing_r ? '0 : s1_r.pix;

    win_nxt = win_r;
    if (s1_v_r) begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i*3]     = win_r[i*3 + 1];
        win_nxt[i*3 + 1] = win_r[i*3 + 2];
      end
      win_nxt[2] = up_eff;
      win_nxt[5] = lo_eff;
      win_nxt[8] = s1_r.pix;
    end

    // zero padding: taps outside the frame see black
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i == 0 && s1_r.top) || (i == 2 && s1_r.bottom) ||
            (j == 0 && s1_r.left) || (j == 2 && s1_r.right)) begin
          q_job.px[i*3 + j] = '0;
        end else begin
          q_job.px[i*3 + j] = win_nxt[i*3 + j];
        end
      end
    end
    q_job.last = s1_r.last;
    q_push     = s1_v_r && s1_r.emit;
  end

  always_ff @(posedge clk) begin
    up_rd_r <= upper_mem[col];
    lo_rd_r <= lower_mem[col];
    if (mem_we) begin
      upper_mem[wr_addr] <= wr_up;
      lower_mem[wr_addr] <= wr_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
      s1_v_r     <= 1'b0;
      byp_v_r    <= 1'b0;
      win_r      <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      clearing_r <= clearing_nxt;
      clr_idx_r  <= clr_idx_nxt;
      s1_v_r     <= accept;
      byp_v_r    <= s1_v_r;
      win_r      <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    byp_col_r <= s1_r.col;
    byp_up_r  <= lo_eff;
    byp_lo_r  <= s1_r.pix;
  end

endmodule
`default_nettype wire

// ===== rtl/rcc_fifo.sv =====
// Short job queue between the window front end and the MAC back end.
`default_nettype none
module rcc_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rcc_pkg::rcc_job_t          push_job,
  input  logic                       pop,
  output logic                       head_valid,
  output rcc_pkg::rcc_job_t          head_job,
  output logic [rcc_pkg::QCNT_W-1:0] count
);
  import rcc_pkg::*;

  rcc_job_t            slot_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign head_valid = (count_r != '0);
  assign head_job   = slot_mem[rd_ptr_r];
  assign count      = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcc_mac.sv =====
// Back end: 27 tap products, row sums, final sum, floor and clamp, output register.
`default_nettype none
module rcc_mac #(
  parameter int COEF_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  rcc_pkg::rcc_job_t job,
  output logic              job_pop,
  input  logic [2:0][47:0]  kernel,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic              out_tlast
);
  import rcc_pkg::*;

  localparam int PW = COEF_WIDTH + 9;
  localparam int SW = COEF_WIDTH + 13;

  logic signed [PW-1:0] prod_r [9][3];
  logic signed [PW-1:0] prod_nxt [9][3];
  logic signed [SW-1:0] rsum_r [3][3];
  logic signed [SW-1:0] rsum_nxt [3][3];
  logic signed [SW-1:0] tot [3];
  logic                 p_v_r, rs_v_r, out_v_r;
  logic                 p_last_r, rs_last_r, out_last_r;
  logic [23:0]          out_data_r, out_data_nxt;
  logic                 en;

  assign en         = !out_v_r || out_tready;
  assign job_pop    = en && job_valid;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int ch = 0; ch < 3; ch++) begin
          prod_nxt[i*3 + j][ch] =
            PW'($signed({1'b0, job.px[i*3 + j][23 - 8*ch -: 8]})) *
            PW'($signed(kernel[i][16*j +: COEF_WIDTH]));
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int ch = 0; ch < 3; ch++) begin
        rsum_nxt[i][ch] = SW'(prod_r[i*3][ch]) + SW'(prod_r[i*3 + 1][ch]) +
                          SW'(prod_r[i*3 + 2][ch]);
      end
    end
    // Q8.8 sum: negative -> 0, floor by 8 bits, saturate at 255
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = rsum_r[0][ch] + rsum_r[1][ch] + rsum_r[2][ch];
      if (tot[ch][SW-1]) begin
        out_data_nxt[8*ch +: 8] = 8'd0;
      end else if (|tot[ch][SW-2:16]) begin
        out_data_nxt[8*ch +: 8] = 8'd255;
      end else begin
        out_data_nxt[8*ch +: 8] = tot[ch][15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r   <= 1'b0;
      rs_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      p_v_r   <= job_valid;
      rs_v_r  <= p_v_r;
      out_v_r <= rs_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r     <= prod_nxt;
      p_last_r   <= job.last;
      rsum_r     <= rsum_nxt;
      rs_last_r  <= p_last_r;
      out_data_r <= out_data_nxt;
      out_last_r <= rs_last_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rgb_conv3x3_zero_pad_clamp.sv =====
// Top level of the RGB 3x3 convolution filter with zero padding and clamping.
`default_nettype none
// Filters an RGB pixel stream in raster order with a 3x3 kernel of signed
// Q8.8 taps per channel; neighbors outside the frame count as black, and
// each sum is floored and clamped to 0..255. The block sustains one item per
// clock while neither side stalls: the front end reads both line stores at
// the item's column and updates them and the window in the next cycle, and
// the MAC back end multiplies all 27 taps in parallel. An item at stream
// position k >= width+1 yields the result for pixel k-width-1; send width+1
// drain items (tuser = 1) after the frame to flush the last row. The frame's
// final result has out_tlast set and the position counters restart after it.
// On its way to the output, a result passes through the line store read,
// the window update and the write into the 4-entry job queue, the products,
// the row sums and the output register, in that order.
// in_tready drops when the job queue cannot take what is in flight, so
// either side can stall without loss. After reset the line stores are
// swept to zero, one entry per clock, over all MAX_WIDTH entries (2048 by
// default); no item is taken during the sweep, configuration writes are.
// Configuration writes belong between frames while the block is idle.
module rgb_conv3x3_zero_pad_clamp #(
  parameter int MAX_WIDTH  = 2048,
  parameter int COEF_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic        in_tuser,   // operation: 0 pixel, 1 drain
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_red [7:0], out_green [15:8], out_blue [23:16]
  output logic        out_tlast,  // last_of_frame
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);
  import rcc_pkg::*;

  // register map
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_KERNEL_ABOVE = 3'd2;
  localparam logic [2:0] CFG_KERNEL_MID   = 3'd3;
  localparam logic [2:0] CFG_KERNEL_BELOW = 3'd4;

  logic [11:0]      frame_width_r, frame_width_nxt;
  logic [15:0]      frame_height_r, frame_height_nxt;
  logic [2:0][47:0] kernel_r, kernel_nxt;   // [0] above, [1] middle, [2] below

  logic              q_push, q_pop, q_head_valid;
  rcc_job_t          q_push_job, q_head_job;
  logic [QCNT_W-1:0] q_count;

  // config decode
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    kernel_nxt       = kernel_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata[11:0];
        CFG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata[15:0];
        CFG_KERNEL_ABOVE: kernel_nxt[0]    = cfg_wdata;
        CFG_KERNEL_MID:   kernel_nxt[1]    = cfg_wdata;
        CFG_KERNEL_BELOW: kernel_nxt[2]    = cfg_wdata;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 12'd640;
      frame_height_r <= 16'd480;
      kernel_r[0]    <= '0;
      kernel_r[1]    <= 48'h0000_0100_0000;  // identity: center tap 1.0
      kernel_r[2]    <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      kernel_r       <= kernel_nxt;
    end
  end

  // counters, line stores, window; builds one masked window job per result
  rcc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_count      (q_count),
    .q_push       (q_push),
    .q_job        (q_push_job)
  );

  // decouples the window from output backpressure
  rcc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .count      (q_count)
  );

  // multiply, accumulate, floor/clamp
  rcc_mac #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (q_head_valid),
    .job        (q_head_job),
    .job_pop    (q_pop),
    .kernel     (kernel_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== verif/rgb_conv3x3_zero_pad_clamp_test.sv =====
// Self-checking testbench for the RGB 3x3 convolution filter with zero padding and clamping.
`timescale 1ns / 100ps
module rgb_conv3x3_zero_pad_clamp_test;
  import rcc_pkg::*;

  localparam int MAX_W          = 2048;
  localparam int COEF_W         = 16;
  localparam int IDLE_MAX       = 15;
  localparam int SETTLE_CYCLES  = 16;    // longer than the pipeline latency
  localparam int LONG_STALL     = 400;   // receiver hold-off used once
  localparam int WATCHDOG_LIMIT = 10000; // covers the line store sweep after reset
  localparam int RANDOM_ITEMS   = 1600;

  typedef enum logic [2:0] {
    REG_WIDTH       = 3'd0,
    REG_HEIGHT      = 3'd1,
    REG_TAPS_ABOVE  = 3'd2,
    REG_TAPS_MIDDLE = 3'd3,
    REG_TAPS_BELOW  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } filtered_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input known from time zero
  // ---------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;       // red [7:0], green [15:8], blue [23:16]
  logic        in_tuser   = OP_PIXEL; // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;             // out_red [7:0], out_green [15:8], out_blue [23:16]
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [47:0] cfg_wdata  = '0;

  rgb_conv3x3_zero_pad_clamp #(
    .MAX_WIDTH  (MAX_W),
    .COEF_WIDTH (COEF_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter predictor: register mirror, line stores, window and counters
  // ---------------------------------------------------------------------------
  logic [11:0] width_cfg  = 12'd640;
  logic [15:0] height_cfg = 16'd480;
  logic [47:0] taps_cfg [3] = '{48'h0, 48'h0000_0100_0000, 48'h0}; // identity at reset

  logic [23:0] upper_line [MAX_W];
  logic [23:0] lower_line [MAX_W];
  logic [23:0] win_pix [9];   // row*3 + column, column 0 = left
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  // Signed Q8.8 tap from a 16-bit slot of a kernel row register
  function automatic int tap_of(logic [47:0] row_taps, int unsigned pos);
    logic [15:0]              slot;
    logic signed [COEF_W-1:0] coef;
    slot = row_taps[16*pos +: 16];
    coef = slot[COEF_W-1:0];
    return int'(coef);
  endfunction

  // Negative -> 0, else floor to integer and saturate at 255
  function automatic logic [7:0] clamp_sum(int sum);
    if (sum < 0) return 8'd0;
    if ((sum >>> 8) > 255) return 8'd255;
    return 8'(sum >>> 8);
  endfunction

  // Advances the filter state by one accepted item; returns 1 when it yields a result
  function automatic bit filter_step(input pixel_item_t item, output filtered_t res);
    int unsigned w, h, col, row, r, c;
    logic [23:0] pix, up, lo, p;
    int          sum [3];
    int          t;
    bit          last;
    w = 32'(width_cfg);
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    h = 32'(height_cfg);
    if (h == 0) h = 1;
    // width shrunk below the current column: wrap to the next row first
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    col = col_pos;
    row = row_pos;
    // drains and anything past the last row enter as black
    pix = (item.op == OP_PIXEL && row < h) ? {item.red, item.green, item.blue} : 24'd0;
    up = upper_line[col];
    lo = lower_line[col];
    upper_line[col] = lo;
    lower_line[col] = pix;
    for (int i = 0; i < 3; i++) begin
      win_pix[i*3]   = win_pix[i*3+1];
      win_pix[i*3+1] = win_pix[i*3+2];
    end
    win_pix[2] = up;
    win_pix[5] = lo;
    win_pix[8] = pix;
    // window center sits one row up and one column left, or at the row end two rows up
    if (col >= 1) begin
      r = row - 1;
      c = col - 1;
    end else begin
      r = (row >= 2) ? row - 2 : 0;
      c = w - 1;
    end
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = row + 1;
    end else begin
      col_pos = col + 1;
    end
    res = '0;
    if (!(row >= 2 || (row == 1 && col >= 1))) return 1'b0;
    last = (r + 1 >= h) && (c + 1 >= w);
    if (last) begin
      col_pos = 0;
      row_pos = 0;
    end
    sum = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      if (i == 0 && r == 0) continue;
      if (i == 2 && r + 1 >= h) continue;   // also covers a shrunk height
      for (int j = 0; j < 3; j++) begin
        if (j == 0 && c == 0) continue;
        if (j == 2 && c + 1 >= w) continue;
        p = win_pix[i*3+j];
        t = tap_of(taps_cfg[i], j);
        for (int ch = 0; ch < 3; ch++)
          sum[ch] += int'(p[23-8*ch -: 8]) * t;
      end
    end
    res.red   = clamp_sum(sum[0]);
    res.green = clamp_sum(sum[1]);
    res.blue  = clamp_sum(sum[2]);
    res.last  = last;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  pixel_item_t pending_pixels [$];   // filled by the stimulus, drained by the driver
  filtered_t   expected_pixels [$];  // predicted results in order
  pixel_item_t offered_item;
  int unsigned in_idle_max  = 0;     // per-item gap bound, sender
  int unsigned out_idle_max = 0;     // per-item hold bound, receiver
  int unsigned in_gap       = 0;
  int unsigned out_wait     = 0;
  int          stall_asked  = 0;     // bumped by the stimulus, taken by the receiver
  int          stall_done   = 0;
  int          error_count  = 0;
  int unsigned quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, predicts at each accepted item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feed_pixels
    filtered_t   produced;
    pixel_item_t next_item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (filter_step(offered_item, produced)) expected_pixels.push_back(produced);
      end
      // slot is free when nothing is offered or the current item goes this edge
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          next_item    = pending_pixels.pop_front();
          offered_item <= next_item;
          in_tdata     <= {next_item.blue, next_item.green, next_item.red};
          in_tuser     <= next_item.op;
          in_tvalid    <= 1'b1;
          in_gap       <= $urandom_range(0, in_idle_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure plus one long hold-off, field compare
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    filtered_t   want;
    int unsigned hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait   <= 0;
    end else begin
      hold = out_wait;
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("result with nothing expected: tdata %h tlast %b", out_tdata, out_tlast);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_red",       want.red,   out_tdata[7:0]);
          check_field("out_green",     want.green, out_tdata[15:8]);
          check_field("out_blue",      want.blue,  out_tdata[23:16]);
          check_field("last_of_frame", 8'(want.last), 8'(out_tlast));
        end
        hold = $urandom_range(0, out_idle_max);
      end
      if (stall_asked != stall_done) begin
        stall_done++;
        hold = LONG_STALL;
      end
      if (hold != 0) begin
        out_tready <= 1'b0;
        out_wait   <= hold - 1;
      end else begin
        out_tready <= 1'b1;
        out_wait   <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles without any accepted item on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [47:0] pack_taps(logic [15:0] left, logic [15:0] center,
                                            logic [15:0] right);
    return {right, center, left};
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly modest taps so sums stay unsaturated, with extremes mixed in
  function automatic logic [15:0] pick_tap();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 16'hFFFF));
      1:       return 16'h0000;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4, 5:    return 16'(-$urandom_range(0, 16'h0100));
      default: return 16'($urandom_range(0, 16'h0180));
    endcase
  endfunction

  function automatic void add_item(logic op, logic [7:0] red, logic [7:0] green,
                                   logic [7:0] blue);
    pixel_item_t item;
    item = '{op: op, red: red, green: green, blue: blue};
    pending_pixels.push_back(item);
  endfunction

  // Config writes at the rising edge; mirror follows once the write has landed
  task automatic write_reg(input cfg_reg_e idx, input logic [47:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_WIDTH:       width_cfg  = value[11:0];
      REG_HEIGHT:      height_cfg = value[15:0];
      REG_TAPS_ABOVE:  taps_cfg[0] = value;
      REG_TAPS_MIDDLE: taps_cfg[1] = value;
      REG_TAPS_BELOW:  taps_cfg[2] = value;
      default: ;
    endcase
  endtask

  // Sender pause: everything sent, every result back, then pipeline latency
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_tvalid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One frame plus width+1 drains. Noisy frames drop in black drains, turn some
  // drains into pixels and now and then stop short so the next frame starts
  // in the middle of the old one.
  task automatic queue_frame(input int unsigned w_eff, input int unsigned h_eff,
                             input bit noisy, output int unsigned count);
    int unsigned pixels, total, cut;
    pixels = w_eff * h_eff;
    total  = pixels + w_eff + 1;
    cut    = (noisy && $urandom_range(0, 11) == 0) ? $urandom_range(1, total - 1) : total;
    count  = 0;
    for (int unsigned k = 0; k < cut; k++) begin
      if (k < pixels)
        add_item((noisy && $urandom_range(0, 19) == 0) ? OP_DRAIN : OP_PIXEL,
                 pick_channel(), pick_channel(), pick_channel());
      else
        add_item((noisy && $urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN,
                 pick_channel(), pick_channel(), pick_channel());
      count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int unsigned random_items, batch, frames, n, w_set, h_set, w_eff, h_eff;
    for (int k = 0; k < MAX_W; k++) begin
      upper_line[k] = '0;
      lower_line[k] = '0;
    end
    for (int k = 0; k < 9; k++) win_pix[k] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // 3x2 frame, saturating taps both ways, black/white and mid-scale pixels,
    // a drain inside the frame and a pixel among the drains
    write_reg(REG_WIDTH, 48'd3);
    write_reg(REG_HEIGHT, 48'd2);
    write_reg(REG_TAPS_ABOVE,  pack_taps(16'h7FFF, 16'h8000, 16'h0100));
    write_reg(REG_TAPS_MIDDLE, pack_taps(16'h0100, 16'h7FFF, 16'hFFFF));
    write_reg(REG_TAPS_BELOW,  pack_taps(16'h8000, 16'h0080, 16'h7FFF));
    @(negedge clk);
    in_idle_max  = 3;
    out_idle_max = 3;
    add_item(OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
    add_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
    add_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    add_item(OP_DRAIN, 8'h5A, 8'hA5, 8'h3C);   // enters as black
    add_item(OP_PIXEL, 8'h01, 8'h80, 8'h7F);
    add_item(OP_PIXEL, 8'hFE, 8'h7F, 8'h80);
    add_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    add_item(OP_PIXEL, 8'hAA, 8'h55, 8'hAA);   // past the frame: colors ignored
    add_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    add_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);

    // width 0 and height 0 both act as 1
    wait_quiet();
    write_reg(REG_WIDTH, 48'd0);
    write_reg(REG_HEIGHT, 48'd0);
    write_reg(REG_TAPS_ABOVE,  48'hFFFF_FFFF_FFFF);
    write_reg(REG_TAPS_MIDDLE, pack_taps(16'h0000, 16'h0100, 16'h0000));
    write_reg(REG_TAPS_BELOW,  48'h0);
    @(negedge clk);
    add_item(OP_PIXEL, 8'h12, 8'h34, 8'h56);
    add_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    add_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);

    // height shrunk mid-frame: two rows of a 65535-row frame, then height 1
    wait_quiet();
    write_reg(REG_WIDTH, 48'd2);
    write_reg(REG_HEIGHT, 48'd65535);
    @(negedge clk);
    add_item(OP_PIXEL, 8'h10, 8'h20, 8'h30);
    add_item(OP_PIXEL, 8'h40, 8'h50, 8'h60);
    add_item(OP_PIXEL, 8'h70, 8'h80, 8'h90);
    add_item(OP_PIXEL, 8'hA0, 8'hB0, 8'hC0);
    wait_quiet();
    write_reg(REG_HEIGHT, 48'd1);
    @(negedge clk);
    add_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);   // flagged last, counters restart

    // width shrunk mid-frame: column 3 of a 4-wide row, then width 2
    wait_quiet();
    write_reg(REG_WIDTH, 48'd4);
    write_reg(REG_HEIGHT, 48'd2);
    @(negedge clk);
    add_item(OP_PIXEL, 8'h11, 8'h22, 8'h33);
    add_item(OP_PIXEL, 8'h44, 8'h55, 8'h66);
    add_item(OP_PIXEL, 8'h77, 8'h88, 8'h99);
    wait_quiet();
    write_reg(REG_WIDTH, 48'd2);
    @(negedge clk);
    add_item(OP_PIXEL, 8'hCC, 8'hDD, 8'hEE);
    add_item(OP_PIXEL, 8'hFF, 8'h01, 8'h02);
    add_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    add_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    add_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);

    // Random batches: new settings each batch, one to three frames in each.
    // Batch 1 holds the receiver off while the sender streams a larger frame.
    random_items = 0;
    batch        = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_quiet();
      if (batch == 1) begin
        w_set = 16;
        h_set = 4;
      end else begin
        case ($urandom_range(0, 15))
          0:       w_set = 0;
          1:       w_set = $urandom_range(17, 64);
          default: w_set = $urandom_range(1, 8);
        endcase
        h_set = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      end
      w_eff = (w_set == 0) ? 1 : (w_set > MAX_W) ? MAX_W : w_set;
      h_eff = (h_set == 0) ? 1 : h_set;
      write_reg(REG_WIDTH, 48'(w_set));
      write_reg(REG_HEIGHT, 48'(h_set));
      write_reg(REG_TAPS_ABOVE,  pack_taps(pick_tap(), pick_tap(), pick_tap()));
      write_reg(REG_TAPS_MIDDLE, pack_taps(pick_tap(), pick_tap(), pick_tap()));
      write_reg(REG_TAPS_BELOW,  pack_taps(pick_tap(), pick_tap(), pick_tap()));
      @(negedge clk);
      in_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, IDLE_MAX);
      out_idle_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, IDLE_MAX);
      if (batch == 1) begin
        in_idle_max = 0;   // keep offering so the job queue backs up
        stall_asked++;
      end
      frames = (batch <= 1) ? 1 : $urandom_range(1, 3);
      repeat (frames) begin
        queue_frame(w_eff, h_eff, batch > 1, n);
        random_items += n;
      end
      batch++;
    end

    wait_quiet();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
